// ===== hw/rtl/sbbf_pkg.sv =====
// Shared constants, register indexes and helpers for the band box finder.
package sbbf_pkg;

    // Default size limits of the frame store
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_THRESHOLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_THRESHOLD = 3'd4;

    // Register reset values
    localparam logic [10:0] RST_FRAME_WIDTH      = 11'd1024;
    localparam logic [10:0] RST_FRAME_HEIGHT     = 11'd1024;
    localparam logic [8:0]  RST_ROW_OFFSET       = 9'd20;
    localparam logic [7:0]  RST_RUN_THRESHOLD    = 8'd190;
    localparam logic [7:0]  RST_COLUMN_THRESHOLD = 8'd210;

    // Packed result width (62 bits of fields, padded to bytes)
    localparam int OUT_DATA_W = 64;

    // Width of one queued command for column and row index widths cw, rw
    function automatic int cmd_width(input int cw, input int rw);
        return 4 * cw + 2 * rw + 4;
    endfunction

    // Size register to effective size: zero reads as one, clamp at the maximum
    function automatic logic [31:0] eff_size(input logic [10:0] v, input int maxv);
        logic [31:0] r;
        if (v == 11'd0) begin
            r = 32'd1;
        end else if (32'(v) > 32'(maxv)) begin
            r = 32'(maxv);
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/spectrum_band_box_finder_core.sv =====
// Dark band box finder: top level joining front end, command queue and back end.
//
// Pixels of a greyscale frame enter on the s_ stream in raster order, one item
// per pixel; s_tuser high marks the first pixel of a frame. On the scan row
// (frame_height/2 - row_offset, floored at 0) each run of pixels darker than
// run_threshold is a band, and one box item leaves on the m_ stream for it,
// carrying left edge, width, centre column, top row, height and scan row.
// Throughput is one pixel per cycle; the front end takes a pixel every cycle
// while the queue has room. The command for the pixel that closes a band
// passes through the queue, the registered column store read at the band
// centre and the output register before its box appears on m_tvalid.
// When m_tready is low the output register holds, the back end stops once
// its lookup stage holds a box, the four-entry queue fills and s_tready drops.
// The per-column top store is never swept: a fill mark that follows the first
// visit of each column in a frame stands in for clearing, so no clearing pass
// is needed after reset. Reset restores the register defaults and restarts the
// raster at row 0, column 0. The user must write registers through cfg_we /
// cfg_index / cfg_wdata only while no item is in flight; it is not enforced.
module spectrum_band_box_finder_core #(
    parameter int MAX_WIDTH  = sbbf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sbbf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sbbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbbf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // pixel[7:0]
    input  logic                            s_tuser,   // frame_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // box_left[9:0], box_width[20:10], box_centre_x[30:21], box_top[40:31],
    // box_height[51:41], centre_row[61:52], zero[63:62]
    output logic [sbbf_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CMD_W = sbbf_pkg::cmd_width(CW, RW);

    logic             f_valid, f_ready;
    logic [CMD_W-1:0] f_data;
    logic             q_valid, q_ready;
    logic [CMD_W-1:0] q_data;

    sbbf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_data  (f_data)
    );

    sbbf_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (sbbf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    sbbf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_data  (q_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== hw/rtl/sbbf_front.sv =====
// Front end: configuration registers, raster counters and band detection.
module sbbf_front #(
    parameter int MAX_WIDTH  = sbbf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sbbf_pkg::DEF_MAX_HEIGHT,
    localparam int CW    = $clog2(MAX_WIDTH),
    localparam int RW    = $clog2(MAX_HEIGHT),
    localparam int CMD_W = sbbf_pkg::cmd_width(CW, RW)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [sbbf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbbf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // pixel stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // pixel[7:0]
    input  logic                             s_tuser,   // frame_start
    // command to the queue
    output logic                             cmd_valid,
    input  logic                             cmd_ready,
    output logic [CMD_W-1:0]                 cmd_data
);

    // Configuration registers
    logic [10:0] frame_width_reg;
    logic [10:0] frame_height_reg;
    logic [8:0]  row_offset_reg;
    logic [7:0]  run_threshold_reg;
    logic [7:0]  column_threshold_reg;

    // Raster and band state
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          open_reg, open_next;
    logic [CW-1:0] start_reg, start_next;
    logic [CW:0]   fill_reg, fill_next;

    logic          push;
    logic [CW:0]   w_eff;
    logic [RW:0]   h_eff;
    logic [31:0]   half32;
    logic [RW-1:0] scan;
    logic [CW-1:0] col_c, start_c;
    logic [RW-1:0] row_c;
    logic          open_c;
    logic [CW:0]   fill_c;
    logic          row_end, last_row;
    logic          top_wr, fill_hit, wr_en;
    logic [RW-1:0] wr_data;
    logic          on_scan, dark, emit;
    logic [CW-1:0] b_start;
    logic [CW:0]   b_end, b_width;
    logic [CW+1:0] b_sum;
    logic [CW-1:0] centre;
    logic          top_ok;

    assign s_tready  = cmd_ready;
    assign cmd_valid = s_tvalid;
    assign push      = s_tvalid && cmd_ready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg      <= sbbf_pkg::RST_FRAME_WIDTH;
            frame_height_reg     <= sbbf_pkg::RST_FRAME_HEIGHT;
            row_offset_reg       <= sbbf_pkg::RST_ROW_OFFSET;
            run_threshold_reg    <= sbbf_pkg::RST_RUN_THRESHOLD;
            column_threshold_reg <= sbbf_pkg::RST_COLUMN_THRESHOLD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sbbf_pkg::REG_FRAME_WIDTH:      frame_width_reg      <= cfg_wdata;
                sbbf_pkg::REG_FRAME_HEIGHT:     frame_height_reg     <= cfg_wdata;
                sbbf_pkg::REG_ROW_OFFSET:       row_offset_reg       <= cfg_wdata[8:0];
                sbbf_pkg::REG_RUN_THRESHOLD:    run_threshold_reg    <= cfg_wdata[7:0];
                sbbf_pkg::REG_COLUMN_THRESHOLD: column_threshold_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Effective frame size and scan row
    always_comb
    begin
        w_eff  = (CW+1)'(sbbf_pkg::eff_size(frame_width_reg, MAX_WIDTH));
        h_eff  = (RW+1)'(sbbf_pkg::eff_size(frame_height_reg, MAX_HEIGHT));
        half32 = 32'(h_eff) >> 1;
        scan   = (half32 > 32'(row_offset_reg)) ? RW'(half32 - 32'(row_offset_reg)) : '0;
    end

    // Classify the pixel and build the command
    always_comb
    begin
        // a frame start restarts everything at this pixel
        col_c   = s_tuser ? '0 : col_reg;
        row_c   = s_tuser ? '0 : row_reg;
        open_c  = s_tuser ? 1'b0 : open_reg;
        start_c = s_tuser ? '0 : start_reg;
        fill_c  = s_tuser ? '0 : fill_reg;

        row_end  = ({1'b0, col_c} + 1'b1) >= w_eff;
        last_row = ({1'b0, row_c} + 1'b1) >= h_eff;

        // column store update; the first visit of a column in a frame also clears it
        top_wr   = (row_c != '0) && (row_c <= scan) && (s_tdata > column_threshold_reg);
        fill_hit = ({1'b0, col_c} == fill_c);
        wr_en    = top_wr || fill_hit;
        wr_data  = top_wr ? row_c : '0;
        fill_next = fill_hit ? fill_c + 1'b1 : fill_c;

        // band open / close on the scan row
        on_scan = (row_c == scan);
        dark    = (s_tdata < run_threshold_reg);
        emit    = on_scan && (dark ? row_end : open_c);
        b_start = (dark && !open_c) ? col_c : start_c;
        b_end   = dark ? ({1'b0, col_c} + 1'b1) : {1'b0, col_c};
        b_width = b_end - {1'b0, b_start};
        b_sum   = {1'b0, b_end} + {2'b00, b_start};
        centre  = b_sum[CW:1];
        top_ok  = (scan != '0) && ({1'b0, centre} < fill_next);

        cmd_data = {wr_en, col_c, wr_data, emit, b_start, b_width, centre, top_ok, scan};

        // next raster state
        open_next  = on_scan ? dark : open_c;
        start_next = b_start;
        row_next   = row_c;
        col_next   = col_c + 1'b1;
        if (row_end)
        begin
            col_next  = '0;
            open_next = 1'b0;
            if (last_row)
            begin
                row_next   = '0;
                fill_next  = '0;
                start_next = '0;
            end
            else
            begin
                row_next = row_c + 1'b1;
            end
        end
    end

    // Raster state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            open_reg  <= 1'b0;
            start_reg <= '0;
            fill_reg  <= '0;
        end
        else if (push)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            open_reg  <= open_next;
            start_reg <= start_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

// ===== hw/rtl/sbbf_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
module sbbf_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sbbf_pkg::QUEUE_DEPTH,
    localparam int PW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != (PW+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/sbbf_back.sv =====
// Back end: column top store, top row lookup and box result register.
module sbbf_back #(
    parameter int MAX_WIDTH  = sbbf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sbbf_pkg::DEF_MAX_HEIGHT,
    localparam int CW    = $clog2(MAX_WIDTH),
    localparam int RW    = $clog2(MAX_HEIGHT),
    localparam int CMD_W = sbbf_pkg::cmd_width(CW, RW)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  logic [CMD_W-1:0]                cmd_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sbbf_pkg::OUT_DATA_W-1:0] m_tdata
);

    // Command fields
    logic          c_wr_en;
    logic [CW-1:0] c_wr_addr;
    logic [RW-1:0] c_wr_data;
    logic          c_emit;
    logic [CW-1:0] c_start;
    logic [CW:0]   c_width;
    logic [CW-1:0] c_centre;
    logic          c_top_ok;
    logic [RW-1:0] c_scan;

    assign {c_wr_en, c_wr_addr, c_wr_data, c_emit, c_start, c_width,
            c_centre, c_top_ok, c_scan} = cmd_data;

    // Column top store
    logic [RW-1:0] top_mem [MAX_WIDTH];
    logic [RW-1:0] rd_reg;

    // Lookup stage
    logic          s1_valid_reg;
    logic [CW-1:0] s1_start_reg;
    logic [CW:0]   s1_width_reg;
    logic [CW-1:0] s1_centre_reg;
    logic          s1_top_ok_reg;
    logic [RW-1:0] s1_scan_reg;
    logic          s1_byp_reg;
    logic [RW-1:0] s1_byp_data_reg;

    // Result register
    logic          out_valid_reg;
    logic [9:0]    out_left_reg;
    logic [10:0]   out_width_reg;
    logic [9:0]    out_centre_reg;
    logic [9:0]    out_top_reg;
    logic [10:0]   out_height_reg;
    logic [9:0]    out_row_reg;

    logic          out_move, adv, pop;
    logic [RW-1:0] top_sel;
    logic [RW:0]   height;

    assign out_move  = !out_valid_reg || m_tready;
    assign adv       = !s1_valid_reg || out_move;
    assign cmd_ready = adv;
    assign pop       = cmd_valid && adv;

    // Store write and registered read at the band centre
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (c_wr_en)
            begin
                top_mem[c_wr_addr] <= c_wr_data;
            end
            rd_reg <= top_mem[c_centre];
        end
    end

    // Lookup stage payload; a write to the centre in the same command is forwarded
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_start_reg    <= c_start;
            s1_width_reg    <= c_width;
            s1_centre_reg   <= c_centre;
            s1_top_ok_reg   <= c_top_ok;
            s1_scan_reg     <= c_scan;
            s1_byp_reg      <= c_wr_en && (c_wr_addr == c_centre);
            s1_byp_data_reg <= c_wr_data;
        end
    end

    // Top row and mirrored height
    always_comb
    begin
        top_sel = s1_byp_reg ? s1_byp_data_reg : rd_reg;
        if (!s1_top_ok_reg)
        begin
            top_sel = '0;
        end
        height = (top_sel <= s1_scan_reg) ? {s1_scan_reg - top_sel, 1'b0} : '0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (out_move && s1_valid_reg)
        begin
            out_left_reg   <= 10'(s1_start_reg);
            out_width_reg  <= 11'(s1_width_reg);
            out_centre_reg <= 10'(s1_centre_reg);
            out_top_reg    <= 10'(top_sel);
            out_height_reg <= 11'(height);
            out_row_reg    <= 10'(s1_scan_reg);
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= pop && c_emit;
            end
            if (out_move)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_row_reg, out_height_reg, out_top_reg,
                       out_centre_reg, out_width_reg, out_left_reg};

endmodule

// ===== sim/tb_spectrum_band_box_finder_core.sv =====
// Self-checking testbench for the dark band box finder core.
`timescale 1ns / 100ps

module tb_spectrum_band_box_finder_core;

    // One pixel item as offered on the input stream
    typedef struct packed {
        logic       fs;
        logic [7:0] pix;
    } pixel_item_t;

    // One box as expected on the output stream
    typedef struct {
        logic [9:0]  left;
        logic [10:0] width;
        logic [9:0]  centre_x;
        logic [9:0]  top;
        logic [10:0] height;
        logic [9:0]  centre_row;
    } box_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [sbbf_pkg::CFG_IDX_W-1:0]  cfg_index = sbbf_pkg::REG_FRAME_WIDTH;
    logic [sbbf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata   = '0;   // pixel[7:0]
    logic                            s_tuser   = 1'b0; // frame_start
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    // box_left[9:0], box_width[20:10], box_centre_x[30:21], box_top[40:31],
    // box_height[51:41], centre_row[61:52], zero[63:62]
    logic [sbbf_pkg::OUT_DATA_W-1:0] m_tdata;

    // Stimulus and scoreboard
    pixel_item_t pixel_backlog[$];
    box_t        box_expect[$];
    int          err_count    = 0;
    int          random_items = 0;
    int          send_idle_pct = 30;
    int          recv_idle_pct = 69;
    bit          hold_go      = 1'b0;
    bit          hold_taken   = 1'b0;
    int          hold_cnt     = 0;

    // Shadow of the registers and the raster state
    logic [10:0] sh_width;
    logic [10:0] sh_height;
    logic [8:0]  sh_offset;
    logic [7:0]  sh_run_thr;
    logic [7:0]  sh_col_thr;
    logic [9:0]  top_store [0:sbbf_pkg::DEF_MAX_WIDTH-1];
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned band_start;
    bit          band_open;

    spectrum_band_box_finder_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Zero reads as one, anything above the store size is clamped
    function automatic int unsigned eff_dim(input logic [10:0] v, input int unsigned maxv);
        if (v == 11'd0)
        begin
            return 1;
        end
        return (v > maxv) ? maxv : int'(v);
    endfunction

    function automatic int unsigned scan_row_now();
        int unsigned half;
        half = eff_dim(sh_height, sbbf_pkg::DEF_MAX_HEIGHT) / 2;
        return (half > sh_offset) ? half - sh_offset : 0;
    endfunction

    function automatic void clear_raster();
        for (int i = 0; i < sbbf_pkg::DEF_MAX_WIDTH; i++)
        begin
            top_store[i] = '0;
        end
        col_cnt    = 0;
        row_cnt    = 0;
        band_start = 0;
        band_open  = 1'b0;
    endfunction

    // Box for band [first, stop) with the top looked up at its centre
    function automatic box_t make_box(input int unsigned first, input int unsigned stop,
                                      input int unsigned scan);
        int unsigned centre;
        int unsigned top;
        int unsigned height;
        box_t        b;
        centre = (first + stop) / 2;
        top    = 0;
        height = 0;
        if (scan > 0 && centre < sbbf_pkg::DEF_MAX_WIDTH)
        begin
            top = top_store[centre];
        end
        if (top <= scan)
        begin
            height = (scan - top) * 2;
        end
        b.left       = 10'(first);
        b.width      = 11'(stop - first);
        b.centre_x   = 10'(centre);
        b.top        = 10'(top);
        b.height     = 11'(height);
        b.centre_row = 10'(scan);
        return b;
    endfunction

    // Advance the raster by one pixel; returns 1 when a band closes
    function automatic bit band_step(input logic [7:0] pix, input logic fs, output box_t bx);
        int unsigned w;
        int unsigned h;
        int unsigned scan;
        int unsigned col;
        int unsigned row;
        bit          row_end;
        bit          hit;
        w    = eff_dim(sh_width, sbbf_pkg::DEF_MAX_WIDTH);
        h    = eff_dim(sh_height, sbbf_pkg::DEF_MAX_HEIGHT);
        scan = scan_row_now();
        hit  = 1'b0;
        bx   = '{default: '0};
        if (fs)
        begin
            clear_raster();
        end
        col     = col_cnt;
        row     = row_cnt;
        row_end = (col + 1 >= w);

        // Column store keeps the latest bright row seen so far up to the scan row
        if (row >= 1 && row <= scan && pix > sh_col_thr && col < sbbf_pkg::DEF_MAX_WIDTH)
        begin
            top_store[col] = 10'(row);
        end

        if (row == scan)
        begin
            if (pix < sh_run_thr)
            begin
                if (!band_open)
                begin
                    band_open  = 1'b1;
                    band_start = col;
                end
                if (row_end)
                begin
                    bx  = make_box(band_start, col + 1, scan);
                    hit = 1'b1;
                end
            end
            else if (band_open)
            begin
                bx        = make_box(band_start, col, scan);
                hit       = 1'b1;
                band_open = 1'b0;
            end
        end

        if (row_end)
        begin
            band_open = 1'b0;
            col_cnt   = 0;
            if (row + 1 >= h)
            begin
                clear_raster();
            end
            else
            begin
                row_cnt = row + 1;
            end
        end
        else
        begin
            col_cnt = col + 1;
        end
        return hit;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // Input driver: offers the next pending pixel, idling at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                pixel_item_t nxt;
                nxt = pixel_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.pix;
                s_tuser  <= nxt.fs;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output ready: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else if (hold_go && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_cnt   <= 250;
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: tracks register writes, predicts on accepted pixels, checks boxes
    always @(posedge clk)
    begin : monitor
        box_t exp_box;
        box_t new_box;
        if (!rst_n)
        begin
            sh_width   = sbbf_pkg::RST_FRAME_WIDTH;
            sh_height  = sbbf_pkg::RST_FRAME_HEIGHT;
            sh_offset  = sbbf_pkg::RST_ROW_OFFSET;
            sh_run_thr = sbbf_pkg::RST_RUN_THRESHOLD;
            sh_col_thr = sbbf_pkg::RST_COLUMN_THRESHOLD;
            clear_raster();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sbbf_pkg::REG_FRAME_WIDTH:      sh_width   = cfg_wdata;
                    sbbf_pkg::REG_FRAME_HEIGHT:     sh_height  = cfg_wdata;
                    sbbf_pkg::REG_ROW_OFFSET:       sh_offset  = cfg_wdata[8:0];
                    sbbf_pkg::REG_RUN_THRESHOLD:    sh_run_thr = cfg_wdata[7:0];
                    sbbf_pkg::REG_COLUMN_THRESHOLD: sh_col_thr = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                if (band_step(s_tdata, s_tuser, new_box))
                begin
                    box_expect.insert(box_expect.size(), new_box);
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (box_expect.size() == 0)
                begin
                    $error("box item with no expectation: %h", m_tdata);
                    err_count++;
                end
                else
                begin
                    exp_box = box_expect.pop_front();
                    check_field("box_left", exp_box.left, m_tdata[9:0]);
                    check_field("box_width", exp_box.width, m_tdata[20:10]);
                    check_field("box_centre_x", exp_box.centre_x, m_tdata[30:21]);
                    check_field("box_top", exp_box.top, m_tdata[40:31]);
                    check_field("box_height", exp_box.height, m_tdata[51:41]);
                    check_field("centre_row", exp_box.centre_row, m_tdata[61:52]);
                    check_field("pad", 0, m_tdata[63:62]);
                end
            end
        end
    end

    function automatic void queue_pixel(input logic [7:0] pix, input logic fs);
        pixel_backlog.insert(pixel_backlog.size(), '{fs: fs, pix: pix});
    endfunction

    task automatic write_reg(input logic [sbbf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sbbf_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every pixel is taken and every box has come, then let the pipe settle
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pixel_backlog.size() != 0 || s_tvalid || box_expect.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [10:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd2047;
            default: return 11'($urandom_range(2, 12));
        endcase
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Pixel values clustered around the live thresholds and the extremes
    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return sh_run_thr - 8'd1;
            3:       return sh_run_thr;
            4:       return sh_col_thr;
            5:       return sh_col_thr + 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One random phase: new settings, then frames, overruns and noise
    task automatic random_phase(input int budget);
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned kind;
        logic        fs;
        if ($urandom_range(0, 1))
        begin
            write_reg(sbbf_pkg::REG_FRAME_WIDTH, pick_size());
        end
        if ($urandom_range(0, 1))
        begin
            write_reg(sbbf_pkg::REG_FRAME_HEIGHT, pick_size());
        end
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 5))
                0:       write_reg(sbbf_pkg::REG_ROW_OFFSET, 11'd0);
                1:       write_reg(sbbf_pkg::REG_ROW_OFFSET, 11'd511);
                2:       write_reg(sbbf_pkg::REG_ROW_OFFSET, 11'($urandom_range(0, 511)));
                default: write_reg(sbbf_pkg::REG_ROW_OFFSET, 11'($urandom_range(0, 3)));
            endcase
        end
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(sbbf_pkg::REG_RUN_THRESHOLD, 11'(pick_level()));
        end
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(sbbf_pkg::REG_COLUMN_THRESHOLD, 11'(pick_level()));
        end
        w = eff_dim(sh_width, sbbf_pkg::DEF_MAX_WIDTH);
        h = eff_dim(sh_height, sbbf_pkg::DEF_MAX_HEIGHT);
        while (budget > 0)
        begin
            kind = $urandom_range(0, 9);
            n    = (kind == 9) ? $urandom_range(1, 2 * w) : w * h;
            for (int unsigned k = 0; k < n && budget > 0; k++)
            begin
                if (kind < 8)
                begin
                    fs = (k == 0);
                end
                else if (kind == 8)
                begin
                    fs = 1'b0;
                end
                else
                begin
                    fs = ($urandom_range(0, 9) == 0);
                end
                queue_pixel(pick_pixel(), fs);
                budget--;
                random_items++;
            end
        end
        wait_drained();
    endtask

    // Stimulus
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Small frame at the reset thresholds: one band closed by a bright pixel,
        // one closed by the row end, then a frame overrun without frame start
        write_reg(sbbf_pkg::REG_FRAME_WIDTH, 11'd4);
        write_reg(sbbf_pkg::REG_FRAME_HEIGHT, 11'd4);
        write_reg(sbbf_pkg::REG_ROW_OFFSET, 11'd0);
        queue_pixel(8'd255, 1'b1);
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd255, 1'b0);
        queue_pixel(8'd211, 1'b0);
        queue_pixel(8'd210, 1'b0);
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd10, 1'b0);
        queue_pixel(8'd190, 1'b0);
        queue_pixel(8'd189, 1'b0);
        for (int i = 0; i < 8; i++)
        begin
            queue_pixel(8'(i * 37), 1'b0);
        end
        wait_drained();

        // Zero sizes read as one: every pixel is a whole frame on scan row zero
        write_reg(sbbf_pkg::REG_FRAME_WIDTH, 11'd0);
        write_reg(sbbf_pkg::REG_FRAME_HEIGHT, 11'd0);
        write_reg(sbbf_pkg::REG_RUN_THRESHOLD, 11'd190);
        write_reg(sbbf_pkg::REG_COLUMN_THRESHOLD, 11'd255);
        queue_pixel(8'd0, 1'b1);
        queue_pixel(8'd255, 1'b0);
        queue_pixel(8'd189, 1'b0);
        queue_pixel(8'd0, 1'b1);
        wait_drained();

        // Oversized width clamps to the store size; a full-width dark band
        write_reg(sbbf_pkg::REG_FRAME_WIDTH, 11'd2047);
        write_reg(sbbf_pkg::REG_FRAME_HEIGHT, 11'd1);
        write_reg(sbbf_pkg::REG_RUN_THRESHOLD, 11'd255);
        write_reg(sbbf_pkg::REG_COLUMN_THRESHOLD, 11'd0);
        for (int c = 0; c < sbbf_pkg::DEF_MAX_WIDTH; c++)
        begin
            queue_pixel(8'd0, c == 0);
        end
        wait_drained();

        // Tallest frame with the largest offset: scan row one, top equals scan row
        write_reg(sbbf_pkg::REG_FRAME_WIDTH, 11'd8);
        write_reg(sbbf_pkg::REG_FRAME_HEIGHT, 11'd2047);
        write_reg(sbbf_pkg::REG_ROW_OFFSET, 11'd511);
        for (int c = 0; c < 8; c++)
        begin
            queue_pixel(8'($urandom_range(0, 255)), c == 0);
        end
        for (int c = 0; c < 8; c++)
        begin
            queue_pixel((c == 3 || c == 6) ? 8'd255
                        : 8'($urandom_range(1, 254)), 1'b0);
        end
        wait_drained();

        // Random phases, idling pattern shifts as the run goes on
        while (random_items < 180)
        begin
            if (random_items < 60)
            begin
                send_idle_pct = 30;
                recv_idle_pct = 69;
            end
            else if (random_items < 120)
            begin
                send_idle_pct = 69;
                recv_idle_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_phase($urandom_range(20, 50));
        end

        // Back-pressure: output held off while dense bands keep coming
        write_reg(sbbf_pkg::REG_FRAME_WIDTH, 11'd16);
        write_reg(sbbf_pkg::REG_FRAME_HEIGHT, 11'd2);
        write_reg(sbbf_pkg::REG_ROW_OFFSET, 11'd0);
        write_reg(sbbf_pkg::REG_RUN_THRESHOLD, 11'd128);
        write_reg(sbbf_pkg::REG_COLUMN_THRESHOLD, 11'd200);
        hold_go = 1'b1;
        for (int f = 0; f < 4; f++)
        begin
            for (int c = 0; c < 16; c++)
            begin
                queue_pixel(8'($urandom_range(0, 255)), c == 0);
            end
            for (int c = 0; c < 16; c++)
            begin
                queue_pixel((c % 2 == 0) ? 8'($urandom_range(0, 127)) : 8'd255, 1'b0);
            end
        end
        wait_drained();

        if (err_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
